[rtl/core/lfev_pkg.sv]
// ----------------------------------------------------------------------------
// lfev_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the LSB frame
// extractor.
// ----------------------------------------------------------------------------
package lfev_pkg;

    localparam int DEF_INDEX_WIDTH       = 16;
    localparam int DEF_PIXEL_COUNT_WIDTH = 20;

    localparam int POS_WIDTH  = 16;   // frame position, bounded by the buffer limit
    localparam int END_WIDTH  = 18;   // record end plus CRC, before the limit check
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_COUNT     = 3'd0,
        CFG_MAX_FRAME_BYTES = 3'd1,
        CFG_FRAME_MAGIC     = 3'd2,
        CFG_FRAME_VERSION   = 3'd3,
        CFG_MAX_RECORDS     = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_VALID   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_VERSION = 3'd3,
        ST_RECORDS = 3'd4,
        ST_BUFFER  = 3'd5,
        ST_IMAGE   = 3'd6,
        ST_CRC     = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_BODY   = 3'd2,
        PH_CRC_HI = 3'd3,
        PH_CRC_LO = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [15:0] max_frame_bytes;
        logic [31:0] frame_magic;
        logic [7:0]  frame_version;
        logic [7:0]  max_records;
    } lfev_cfg_t;

    typedef struct packed {
        logic                 valid;
        logic [7:0]           payload_byte;
        logic [POS_WIDTH-1:0] byte_index;
        logic                 frame_done;
        status_t              status;
        logic [POS_WIDTH-1:0] frame_length;
    } lfev_result_t;

    // MSB-first CRC-16 update over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/lfev_frame_parser.sv]
// ----------------------------------------------------------------------------
// lfev_frame_parser
// Frame parser: header checks, record walk, running CRC and final compare.
// Result for a completed byte is combinational; state updates on the strobe.
// ----------------------------------------------------------------------------
module lfev_frame_parser
    import lfev_pkg::*;
#(
    parameter int CAP_WIDTH = DEF_PIXEL_COUNT_WIDTH - 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfev_cfg_t            cfg,
    input  logic [CAP_WIDTH-1:0] capacity,
    input  logic                 byte_strobe,
    input  logic [7:0]           byte_value,
    input  logic                 restart,
    output lfev_result_t         result
);

    localparam int CMP_WIDTH = (CAP_WIDTH > END_WIDTH) ? CAP_WIDTH : END_WIDTH;

    phase_t               phase_reg, phase_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [7:0]           records_reg, records_next;
    logic [8:0]           rec_bytes_reg, rec_bytes_next;
    logic [15:0]          crc_reg, crc_next;
    logic [7:0]           crc_hi_reg, crc_hi_next;

    logic [CMP_WIDTH-1:0] cap_ext;
    logic [CMP_WIDTH-1:0] mfb_ext;
    logic [CMP_WIDTH-1:0] end_crc;
    logic [1:0]           magic_sel;
    logic [7:0]           magic_byte;
    logic [15:0]          crc_upd;
    logic [8:0]           rec_bytes_dec;
    logic [7:0]           records_dec;
    status_t              st;
    logic                 done;
    logic                 hit;
    logic [POS_WIDTH-1:0] len;

    assign cap_ext    = CMP_WIDTH'(capacity);
    assign mfb_ext    = CMP_WIDTH'(cfg.max_frame_bytes);
    // pos + 1 + L + 8, plus two CRC bytes
    assign end_crc    = CMP_WIDTH'(pos_reg) + CMP_WIDTH'(byte_value) + CMP_WIDTH'(11);
    assign magic_sel  = 2'd3 - pos_reg[1:0];
    assign magic_byte = cfg.frame_magic[{magic_sel, 3'b000} +: 8];
    assign crc_upd    = crc16_byte(crc_reg, byte_value);
    assign rec_bytes_dec = rec_bytes_reg - 9'd1;
    assign records_dec   = records_reg - 8'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        records_next   = records_reg;
        rec_bytes_next = rec_bytes_reg;
        crc_next       = crc_reg;
        crc_hi_next    = crc_hi_reg;
        st             = ST_OK;
        done           = 1'b0;
        hit            = 1'b1;
        len            = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                priority if (pos_reg == '0 && cfg.max_frame_bytes < 16'd6)
                    st = ST_BUFFER;
                else if (pos_reg == '0 && cap_ext < CMP_WIDTH'(6))
                    st = ST_IMAGE;
                else if (pos_reg < POS_WIDTH'(4))
                begin
                    if (byte_value != magic_byte)
                        st = ST_MAGIC;
                end
                else if (pos_reg == POS_WIDTH'(4))
                begin
                    if (byte_value != cfg.frame_version)
                        st = ST_VERSION;
                end
                else if (byte_value > cfg.max_records)
                    st = ST_RECORDS;
                else if (byte_value != 8'd0)
                begin
                    // first record byte must fit
                    priority if (cfg.max_frame_bytes < 16'd7)
                        st = ST_BUFFER;
                    else if (cap_ext <= CMP_WIDTH'(6))
                        st = ST_IMAGE;
                    else
                    begin
                        records_next = byte_value;
                        phase_next   = PH_LENGTH;
                    end
                end
                else
                begin
                    // no records: the CRC must fit
                    priority if (cfg.max_frame_bytes < 16'd8)
                        st = ST_BUFFER;
                    else if (cap_ext < CMP_WIDTH'(8))
                        st = ST_IMAGE;
                    else
                        phase_next = PH_CRC_HI;
                end
                crc_next = crc_upd;
            end
            PH_LENGTH:
            begin
                priority if (end_crc > mfb_ext)
                    st = ST_BUFFER;
                else if (end_crc > cap_ext)
                    st = ST_IMAGE;
                else
                begin
                    rec_bytes_next = {1'b0, byte_value} + 9'd8;
                    phase_next     = PH_BODY;
                end
                crc_next = crc_upd;
            end
            PH_BODY:
            begin
                rec_bytes_next = rec_bytes_dec;
                if (rec_bytes_dec == '0)
                begin
                    records_next = records_dec;
                    phase_next   = (records_dec != '0) ? PH_LENGTH : PH_CRC_HI;
                end
                crc_next = crc_upd;
            end
            PH_CRC_HI:
            begin
                crc_hi_next = byte_value;
                phase_next  = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                done = 1'b1;
                if ({crc_hi_reg, byte_value} == crc_reg)
                begin
                    st  = ST_VALID;
                    len = pos_reg + POS_WIDTH'(1);
                end
                else
                begin
                    st = ST_CRC;
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase

        if (st != ST_OK)
            done = 1'b1;
        if (hit)
        begin
            if (done)
                phase_next = PH_DONE;
            pos_next = pos_reg + POS_WIDTH'(1);
        end

        result.valid        = byte_strobe && hit;
        result.payload_byte = byte_value;
        result.byte_index   = pos_reg;
        result.frame_done   = done;
        result.status       = st;
        result.frame_length = len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            records_reg   <= '0;
            rec_bytes_reg <= '0;
            crc_reg       <= CRC_INIT;
            crc_hi_reg    <= '0;
        end
        else if (restart)
        begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            records_reg   <= '0;
            rec_bytes_reg <= '0;
            crc_reg       <= CRC_INIT;
            crc_hi_reg    <= '0;
        end
        else if (byte_strobe)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            records_reg   <= records_next;
            rec_bytes_reg <= rec_bytes_next;
            crc_reg       <= crc_next;
            crc_hi_reg    <= crc_hi_next;
        end
    end

endmodule

[rtl/core/lsb_frame_extract_validate.sv]
// ----------------------------------------------------------------------------
// lsb_frame_extract_validate
// Gathers channel-byte LSBs into frame bytes, parses and checks the frame.
// ----------------------------------------------------------------------------
// Throughput: one channel byte per cycle, at most one result per 8 channel bytes.
// Latency: the result of a byte is in the output register the cycle after its
// eighth channel byte is accepted. Only that eighth byte waits on a stalled
// output; the other seven are taken regardless.
// Reset: rst_n asynchronous, resets gatherer, counters, parser, config, out valid.
module lsb_frame_extract_validate
    import lfev_pkg::*;
#(
    parameter int INDEX_WIDTH       = DEF_INDEX_WIDTH,
    parameter int PIXEL_COUNT_WIDTH = DEF_PIXEL_COUNT_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // channel bytes
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] channel_byte
    // frame bytes
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [((8 + 2*INDEX_WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
                                            // payload_byte, byte_index, frame_length
    output logic                 m_tlast,   // frame_done
    output logic [2:0]           m_tuser    // status
);

    localparam int LIMIT_WIDTH = PIXEL_COUNT_WIDTH + 2;
    localparam int CAP_WIDTH   = LIMIT_WIDTH - 3;
    localparam int TDATA_WIDTH = ((8 + 2*INDEX_WIDTH + 7) / 8) * 8;

    lfev_cfg_t              cfg_reg;
    logic [LIMIT_WIDTH-1:0] limit_reg;     // 3 * pixel_count
    logic [PIXEL_COUNT_WIDTH-1:0] pc_wr;

    logic [7:0]             gather_reg, gather_next;
    logic [2:0]             nbits_reg;
    logic [LIMIT_WIDTH-1:0] count_reg, count_next;
    logic                   accept;
    logic                   byte_full;
    logic                   restart;

    lfev_result_t           result;
    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg;
    logic [INDEX_WIDTH-1:0] out_index_reg;
    logic [INDEX_WIDTH-1:0] out_len_reg;
    logic                   out_done_reg;
    status_t                out_status_reg;

    assign pc_wr = cfg_wdata[PIXEL_COUNT_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg               <= '0;
            cfg_reg.max_frame_bytes <= 16'hFFFF;
            cfg_reg.frame_magic     <= '0;
            cfg_reg.frame_version   <= '0;
            cfg_reg.max_records     <= 8'hFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIXEL_COUNT:
                    limit_reg <= LIMIT_WIDTH'(pc_wr) + {1'b0, pc_wr, 1'b0};
                CFG_MAX_FRAME_BYTES:
                    cfg_reg.max_frame_bytes <= cfg_wdata[15:0];
                CFG_FRAME_MAGIC:
                    cfg_reg.frame_magic <= cfg_wdata[31:0];
                CFG_FRAME_VERSION:
                    cfg_reg.frame_version <= cfg_wdata[7:0];
                CFG_MAX_RECORDS:
                    cfg_reg.max_records <= cfg_wdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // only a byte-completing request needs room at the output
    assign byte_full   = (nbits_reg == 3'd7);
    assign s_tready    = !out_valid_reg || m_tready || !byte_full;
    assign accept      = s_tvalid && s_tready;
    assign gather_next = {gather_reg[6:0], s_tdata[0]};
    assign count_next  = count_reg + LIMIT_WIDTH'(1);
    assign restart     = accept && (count_next >= limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_reg <= '0;
            nbits_reg  <= '0;
            count_reg  <= '0;
        end
        else if (restart)
        begin
            gather_reg <= '0;
            nbits_reg  <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            gather_reg <= gather_next;
            nbits_reg  <= nbits_reg + 3'd1;
            count_reg  <= count_next;
        end
    end

    lfev_frame_parser #(
        .CAP_WIDTH (CAP_WIDTH)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .capacity    (limit_reg[LIMIT_WIDTH-1:3]),
        .byte_strobe (accept && byte_full),
        .byte_value  (gather_next),
        .restart     (restart),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (result.valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_byte_reg   <= result.payload_byte;
            out_index_reg  <= INDEX_WIDTH'(result.byte_index);
            out_len_reg    <= INDEX_WIDTH'(result.frame_length);
            out_done_reg   <= result.frame_done;
            out_status_reg <= result.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_WIDTH'({out_len_reg, out_index_reg, out_byte_reg});
    assign m_tlast  = out_done_reg;
    assign m_tuser  = out_status_reg;

`ifndef SYNTHESIS
    a_valid_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status_reg == ST_VALID) |-> out_done_reg)
        else $error("frame valid status without frame end");

    a_len_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_len_reg != '0) |-> (out_status_reg == ST_VALID))
        else $error("frame length on a non-valid result");

    a_result_from_eighth_bit: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> accept && byte_full)
        else $error("result without a completed byte");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (nbits_reg == 3'd0) && (count_reg == '0))
        else $error("image restart did not clear gatherer");
`endif

endmodule
